// ===== rtl/core/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared sizes and types for the LRU key-value cache and its recency cells.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int CAP_W       = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } lkv_cmd_t;

    // Broadcast from the top level to every cell.
    typedef struct packed
    {
        logic                    clear;
        logic                    update;
        logic                    hit;
        logic                    evict;
        logic signed [KEY_W-1:0] key;
    } lkv_ctrl_t;

    // Contents of one cell, handed down the chain on a shift.
    typedef struct packed
    {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } lkv_entry_t;

    // Lookup results accumulated along the chain.
    typedef struct packed
    {
        logic                    found;
        logic [VAL_W-1:0]        rd;
        logic signed [KEY_W-1:0] evk;
    } lkv_scan_t;

endpackage

// ===== rtl/core/lkv_req_if.sv =====
// ----------------------------------------------------------------------------
// lkv_req_if
// Request channel of the LRU key-value cache.
// ----------------------------------------------------------------------------
interface lkv_req_if;

    logic                            valid;
    logic                            ready;
    logic                            command;
    logic signed [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0]       value;

    modport source
    (
        output valid,
        output command,
        output key,
        output value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  key,
        input  value,
        output ready
    );

endinterface

// ===== rtl/core/lkv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lkv_rsp_if
// Response channel of the LRU key-value cache.
// ----------------------------------------------------------------------------
interface lkv_rsp_if;

    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [lkv_pkg::VAL_W-1:0]       read_value;
    logic                            evicted;
    logic signed [lkv_pkg::KEY_W-1:0] evicted_key;

    modport source
    (
        output valid,
        output hit,
        output read_value,
        output evicted,
        output evicted_key,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  hit,
        input  read_value,
        input  evicted,
        input  evicted_key,
        output ready
    );

endinterface

// ===== rtl/core/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// lkv_cell
// One recency position: holds an entry, compares it with the request key and
// takes its upstream neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module lkv_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lkv_pkg::lkv_ctrl_t   ctrl,
    input  lkv_pkg::lkv_entry_t  prev,
    input  lkv_pkg::lkv_scan_t   scan_in,
    input  logic                 next_valid,
    output lkv_pkg::lkv_entry_t  entry,
    output lkv_pkg::lkv_scan_t   scan_out,
    output logic                 match
);

    logic                            valid_reg;
    logic                            valid_next;
    logic signed [lkv_pkg::KEY_W-1:0] key_reg;
    logic signed [lkv_pkg::KEY_W-1:0] key_next;
    logic [lkv_pkg::VAL_W-1:0]       value_reg;
    logic [lkv_pkg::VAL_W-1:0]       value_next;
    logic                            shift;
    logic                            last_valid;

    assign match      = valid_reg && (key_reg == ctrl.key);
    assign last_valid = valid_reg && !next_valid;

    // A hit moves every position up to and including the hit one; an insert
    // moves every position up to the free slot or, on eviction, the last one.
    always_comb
    begin
        if (!ctrl.update)
        begin
            shift = 1'b0;
        end
        else if (ctrl.hit)
        begin
            shift = !scan_in.found;
        end
        else if (ctrl.evict)
        begin
            shift = valid_reg;
        end
        else
        begin
            shift = prev.valid;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = prev.valid;
            key_next   = prev.key;
            value_next = prev.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

    assign scan_out.found = scan_in.found | match;
    assign scan_out.rd    = scan_in.rd | (match ? value_reg : '0);
    assign scan_out.evk   = scan_in.evk | (last_valid ? key_reg : '0);

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The cache takes at most one request transaction per clock cycle and returns
// one response transaction per request, in order, through an output register
// that is loaded when the request is accepted. A new request is accepted while
// the output register is empty or in the cycle its response is taken, so
// requests follow back to back when responses are taken at once, and the
// request side stalls while a response waits. Entries sit in a chain of cells
// ordered from most to least recent; every cell compares its key with the
// request in the same cycle and the chain shifts by one position behind a hit
// or an insertion. Writing the capacity register, and reset, empty the cache
// at once.
module lru_key_value_cache
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]  cfg_wdata,
    lkv_req_if.sink                    req,
    lkv_rsp_if.source                  rsp
);

    logic [lkv_pkg::CAP_W-1:0]       cap_reg;
    logic [lkv_pkg::CAP_W-1:0]       cap_next;
    logic [lkv_pkg::CNT_W-1:0]       fill_count_reg;
    logic [lkv_pkg::CNT_W-1:0]       fill_count_next;
    logic [lkv_pkg::CMP_W-1:0]       cap_ext;
    logic [lkv_pkg::CMP_W-1:0]       eff_cap;
    logic                            full;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic [lkv_pkg::VAL_W-1:0]       read_value_reg;
    logic [lkv_pkg::VAL_W-1:0]       read_value_next;
    logic                            evicted_reg;
    logic                            evicted_next;
    logic signed [lkv_pkg::KEY_W-1:0] evicted_key_reg;
    logic signed [lkv_pkg::KEY_W-1:0] evicted_key_next;

    logic                            req_fire;
    logic                            is_set;
    logic                            hit;
    logic                            evict;

    lkv_pkg::lkv_ctrl_t              ctrl;
    lkv_pkg::lkv_entry_t             entry_link [lkv_pkg::MAX_ENTRIES+1];
    lkv_pkg::lkv_scan_t              scan_link  [lkv_pkg::MAX_ENTRIES+1];
    logic [lkv_pkg::MAX_ENTRIES-1:0] match_vec;
    logic [lkv_pkg::MAX_ENTRIES-1:0] valid_vec;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign is_set    = (lkv_pkg::lkv_cmd_t'(req.command) == lkv_pkg::CMD_SET);

    always_comb
    begin
        cap_ext = lkv_pkg::CMP_W'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = lkv_pkg::CMP_W'(1);
        end
        else if (cap_ext > lkv_pkg::CMP_W'(lkv_pkg::MAX_ENTRIES))
        begin
            eff_cap = lkv_pkg::CMP_W'(lkv_pkg::MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full  = lkv_pkg::CMP_W'(fill_count_reg) >= eff_cap;
    assign hit   = scan_link[lkv_pkg::MAX_ENTRIES].found;
    assign evict = is_set && !hit && full;

    assign ctrl.clear  = cfg_we;
    assign ctrl.update = req_fire && !cfg_we && (hit || is_set);
    assign ctrl.hit    = hit;
    assign ctrl.evict  = evict;
    assign ctrl.key    = req.key;

    // The head of the chain receives the request as the new most recent entry.
    assign entry_link[0].valid = 1'b1;
    assign entry_link[0].key   = req.key;
    assign entry_link[0].value = is_set ? req.value : scan_link[lkv_pkg::MAX_ENTRIES].rd;

    assign scan_link[0].found = 1'b0;
    assign scan_link[0].rd    = '0;
    assign scan_link[0].evk   = '0;

    for (genvar p = 0; p < lkv_pkg::MAX_ENTRIES; p++)
    begin : g_cell
        logic next_valid;

        if (p == lkv_pkg::MAX_ENTRIES - 1)
        begin : g_tail
            assign next_valid = 1'b0;
        end
        else
        begin : g_body
            assign next_valid = entry_link[p+2].valid;
        end

        lkv_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev       (entry_link[p]),
            .scan_in    (scan_link[p]),
            .next_valid (next_valid),
            .entry      (entry_link[p+1]),
            .scan_out   (scan_link[p+1]),
            .match      (match_vec[p])
        );

        assign valid_vec[p] = entry_link[p+1].valid;
    end

    always_comb
    begin
        cap_next        = cap_reg;
        fill_count_next = fill_count_reg;
        if (cfg_we)
        begin
            cap_next        = cfg_wdata;
            fill_count_next = '0;
        end
        else if (req_fire && is_set && !hit && !full)
        begin
            fill_count_next = fill_count_reg + lkv_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        hit_next         = hit_reg;
        read_value_next  = read_value_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;
        if (req_fire)
        begin
            out_valid_next   = 1'b1;
            hit_next         = hit;
            read_value_next  = (hit && !is_set) ? scan_link[lkv_pkg::MAX_ENTRIES].rd : '0;
            evicted_next     = evict;
            evicted_key_next = evict ? scan_link[lkv_pkg::MAX_ENTRIES].evk : '0;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= lkv_pkg::CAP_RESET;
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg         <= hit_next;
        read_value_reg  <= read_value_next;
        evicted_reg     <= evicted_next;
        evicted_key_reg <= evicted_key_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.evicted     = evicted_reg;
    assign rsp.evicted_key = evicted_key_reg;

    // Keys are unique, so at most one cell can match a request.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("More than one cell matched the request key.");

    // The valid cells form a prefix of the chain; their number must equal the fill count.
    a_fill_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == fill_count_reg)
        else $error("Fill count disagrees with the valid cells.");

    a_fill_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        lkv_pkg::CMP_W'(fill_count_reg) <= eff_cap)
        else $error("Fill count exceeds the effective capacity.");

    // A set always leaves its key at the most recent position.
    a_set_lands_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && is_set && !cfg_we |=> valid_vec[0] && (entry_link[1].key == $past(req.key)))
        else $error("Set key is not at the head of the recency chain.");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the LRU key-value cache. Get and set requests go in
// through the request channel with random gaps. A cycle-free model of the
// store and its recency order predicts every response. Responses are taken
// with random back-pressure and compared field by field, in order. Phases
// run at different capacity settings, including zero and values above the
// entry count.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int MAX_REPORTS = 10;

    typedef struct
    {
        lkv_pkg::lkv_cmd_t                command;
        logic signed [lkv_pkg::KEY_W-1:0] key;
        logic [lkv_pkg::VAL_W-1:0]        value;
        bit                               drain;
    } cache_request_t;

    typedef struct packed
    {
        logic                             hit;
        logic [lkv_pkg::VAL_W-1:0]        read_value;
        logic                             evicted;
        logic signed [lkv_pkg::KEY_W-1:0] evicted_key;
    } cache_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [lkv_pkg::CAP_W-1:0] cfg_wdata;

    lkv_req_if req_ch();
    lkv_rsp_if rsp_ch();

    lru_key_value_cache u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    cache_request_t request_queue[$];
    cache_result_t  pending_responses[$];

    logic signed [lkv_pkg::KEY_W-1:0] slot_key[lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]        slot_val[lkv_pkg::MAX_ENTRIES];
    bit                               slot_live[lkv_pkg::MAX_ENTRIES];
    int                               lru_order[lkv_pkg::MAX_ENTRIES];
    int                               live_count;
    logic [lkv_pkg::CAP_W-1:0]        cap_reg;

    bit req_taken;
    bit rsp_taken;
    int rsp_count;
    int mismatch_count;
    int idle_cycles;
    int send_wait;
    int recv_wait;
    int hold_left;
    bit send_calm;
    bit recv_calm;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void clear_store();
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            slot_live[i] = 1'b0;
            lru_order[i] = i;
        end
        live_count = 0;
    endfunction

    function automatic void move_to_front(int at);
        int moved;
        moved = lru_order[at];
        for (int p = at; p > 0; p--)
        begin
            lru_order[p] = lru_order[p - 1];
        end
        lru_order[0] = moved;
    endfunction

    function automatic cache_result_t cache_access(cache_request_t r);
        cache_result_t res;
        int at;
        int slot;
        int limit;
        res = '0;
        at = -1;
        for (int p = 0; p < live_count; p++)
        begin
            if (at < 0 && slot_live[lru_order[p]] && slot_key[lru_order[p]] == r.key)
            begin
                at = p;
            end
        end
        if (at >= 0)
        begin
            slot = lru_order[at];
            res.hit = 1'b1;
            if (r.command == lkv_pkg::CMD_GET)
            begin
                res.read_value = slot_val[slot];
            end
            else
            begin
                slot_val[slot] = r.value;
            end
            move_to_front(at);
        end
        else if (r.command == lkv_pkg::CMD_SET)
        begin
            limit = (cap_reg == 0) ? 1
                  : ((cap_reg > lkv_pkg::MAX_ENTRIES) ? lkv_pkg::MAX_ENTRIES : cap_reg);
            if (live_count >= limit)
            begin
                at = live_count - 1;
                slot = lru_order[at];
                res.evicted = 1'b1;
                res.evicted_key = slot_key[slot];
            end
            else
            begin
                at = live_count;
                slot = lru_order[at];
                live_count++;
            end
            slot_key[slot] = r.key;
            slot_val[slot] = r.value;
            slot_live[slot] = 1'b1;
            move_to_front(at);
        end
        return res;
    endfunction

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0)
        begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void check_response(cache_result_t got);
        cache_result_t want;
        if (pending_responses.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("unexpected response transaction: hit=%0b rd=%h ev=%0b evk=%h",
                         got.hit, got.read_value, got.evicted, got.evicted_key);
            end
            return;
        end
        want = pending_responses.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("response %0d: expected hit=%0b rd=%h ev=%0b evk=%h", rsp_count,
                         want.hit, want.read_value, want.evicted, want.evicted_key);
                $display("response %0d: actual   hit=%0b rd=%h ev=%0b evk=%h", rsp_count,
                         got.hit, got.read_value, got.evicted, got.evicted_key);
            end
        end
    endfunction

    // Prediction happens in acceptance order, so the model sees the same
    // sequence of capacity writes and requests as the cache.
    always @(posedge clk)
    begin
        cache_request_t r;
        cache_result_t  got;
        if (!rst_n)
        begin
            cap_reg = lkv_pkg::CAP_RESET;
            clear_store();
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            rsp_taken <= rsp_ch.valid && rsp_ch.ready;
            if (cfg_we)
            begin
                cap_reg = cfg_wdata;
                clear_store();
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.hit = rsp_ch.hit;
                got.read_value = rsp_ch.read_value;
                got.evicted = rsp_ch.evicted;
                got.evicted_key = rsp_ch.evicted_key;
                check_response(got);
                rsp_count++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r.command = lkv_pkg::lkv_cmd_t'(req_ch.command);
                r.key = req_ch.key;
                r.value = req_ch.value;
                r.drain = 1'b0;
                pending_responses.push_back(cache_access(r));
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // An item marked drain is held back until every response is in.
    always @(negedge clk)
    begin
        cache_request_t r;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                req_ch.valid <= 1'b0;
            end
            else if (request_queue.size() != 0 &&
                     (!request_queue[0].drain || pending_responses.size() == 0))
            begin
                r = request_queue.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.command <= r.command;
                req_ch.key <= r.key;
                req_ch.value <= r.value;
                send_wait = draw_gap(send_calm);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                recv_wait = draw_gap(recv_calm);
                if (rsp_count % 500 == 250)
                begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void add_request(lkv_pkg::lkv_cmd_t cmd,
                                        logic signed [lkv_pkg::KEY_W-1:0] key,
                                        logic [lkv_pkg::VAL_W-1:0] value);
        cache_request_t r;
        r.command = cmd;
        r.key = key;
        r.value = value;
        r.drain = 1'b0;
        request_queue.push_back(r);
    endfunction

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (request_queue.size() != 0 || pending_responses.size() != 0 || req_ch.valid);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap_value);
        wait_idle();
        cfg_wdata <= cap_value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [lkv_pkg::CAP_W-1:0] cap_value, int count);
        logic signed [lkv_pkg::KEY_W-1:0] key_pool[$];
        cache_request_t                   r;
        int                               eff;
        int                               pool_size;
        write_capacity(cap_value);
        eff = (cap_value == 0) ? 1
            : ((cap_value > lkv_pkg::MAX_ENTRIES) ? lkv_pkg::MAX_ENTRIES : cap_value);
        pool_size = eff + $urandom_range(1, 4);
        for (int i = 0; i < pool_size; i++)
        begin
            key_pool.push_back($urandom);
        end
        if ($urandom_range(0, 1))
        begin
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7fff_ffff;
        end
        for (int i = 0; i < count; i++)
        begin
            r.command = lkv_pkg::lkv_cmd_t'($urandom_range(0, 1));
            r.key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_size - 1)]
                                               : $urandom;
            r.value = lkv_pkg::VAL_W'($urandom);
            r.drain = (i == count / 2);
            request_queue.push_back(r);
        end
    endtask

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.command = lkv_pkg::CMD_GET;
        req_ch.key = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        send_wait = 0;
        recv_wait = 0;
        hold_left = 0;
        rsp_count = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_request(lkv_pkg::CMD_GET, 32'h0000_0000, 31'h7fff_ffff);
        add_request(lkv_pkg::CMD_SET, 32'h8000_0000, 31'h7fff_ffff);
        add_request(lkv_pkg::CMD_SET, 32'h7fff_ffff, 31'h0000_0000);
        add_request(lkv_pkg::CMD_SET, 32'hffff_ffff, 31'h0000_0001);
        add_request(lkv_pkg::CMD_GET, 32'h8000_0000, 31'h0000_0000);
        add_request(lkv_pkg::CMD_GET, 32'hffff_ffff, 31'h2aaa_aaaa);
        add_request(lkv_pkg::CMD_SET, 32'h7fff_ffff, 31'h5555_5555);
        add_request(lkv_pkg::CMD_GET, 32'h7fff_ffff, 31'h0000_0000);
        add_request(lkv_pkg::CMD_GET, 32'h1234_5678, 31'h0000_0000);

        write_capacity(5'd1);
        add_request(lkv_pkg::CMD_SET, 32'h0000_00aa, 31'h0000_0011);
        add_request(lkv_pkg::CMD_SET, 32'hffff_ffff, 31'h0000_0022);
        add_request(lkv_pkg::CMD_GET, 32'h0000_00aa, 31'h0000_0000);
        add_request(lkv_pkg::CMD_GET, 32'hffff_ffff, 31'h0000_0000);
        add_request(lkv_pkg::CMD_SET, 32'hffff_ffff, 31'h0000_0033);
        add_request(lkv_pkg::CMD_SET, 32'h0000_00bb, 31'h0000_0044);

        // Touching the older key must make the other one the eviction victim.
        write_capacity(5'd2);
        add_request(lkv_pkg::CMD_SET, 32'h0000_0001, 31'h0000_0101);
        add_request(lkv_pkg::CMD_SET, 32'h0000_0002, 31'h0000_0202);
        add_request(lkv_pkg::CMD_GET, 32'h0000_0001, 31'h0000_0000);
        add_request(lkv_pkg::CMD_SET, 32'h0000_0003, 31'h0000_0303);
        add_request(lkv_pkg::CMD_GET, 32'h0000_0002, 31'h0000_0000);

        run_phase(5'd31, 150);
        run_phase(5'd0, 150);
        run_phase(5'd1, 150);
        run_phase(5'd16, 150);
        run_phase(5'd17, 150);
        run_phase(5'd2, 150);
        run_phase(5'd8, 150);
        run_phase(5'($urandom_range(0, 31)), 150);
        run_phase(5'($urandom_range(3, 15)), 150);
        run_phase(5'($urandom_range(0, 31)), 150);

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lkv_pkg.sv
rtl/core/lkv_req_if.sv
rtl/core/lkv_rsp_if.sv
rtl/core/lkv_cell.sv
rtl/core/lru_key_value_cache.sv
test/testbench.sv
